// ----- hdl/kpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpc_pkg
// Field widths, register indexes and small helpers for the k-mer profile
// counter.
// ----------------------------------------------------------------------------
package kpc_pkg;

    localparam int FUNC_W      = 1;
    localparam int SEQ_ID_W    = 4;
    localparam int SYMBOL_W    = 8;
    localparam int READ_IDX_W  = 12;
    localparam int KMER_IDX_W  = 12;
    localparam int COUNT_W     = 16;
    localparam int ALPHA_W     = 6;
    localparam int KLEN_W      = 4;
    localparam int SYM_W       = 5;
    localparam int MAX_ALPHA   = 32;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 6'd4;
    localparam logic [KLEN_W-1:0]  KLEN_RESET  = 4'd3;

    // Register index, taken from bit 2 of the byte address.
    typedef enum logic {
        REG_ALPHABET_SIZE = 1'b0,
        REG_KMER_LEN      = 1'b1
    } reg_idx_t;

    typedef enum logic {
        FUNC_PUSH = 1'b0,
        FUNC_READ = 1'b1
    } func_t;

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        sat_inc = (v == {COUNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

// ----- hdl/kmer_profile_counter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kmer_profile_counter
// Per-sequence k-mer count profiles built from a stream of symbol codes,
// with saturating 16-bit counters and per-sequence lengths.
// ----------------------------------------------------------------------------
// After reset the block clears all NUM_SEQS * 2**ceil(log2(TABLE_DEPTH))
// entries (65536 at the defaults) of its count memory and holds s_ready low
// meanwhile; configuration writes are taken throughout. Each beat then
// passes through an accept step, one multiply-add step per k-mer symbol to
// form the base-alphabet index and check alphabet_size**kmer_len against
// the table depth, a step for the synchronous read of the count and length
// memories, and one for the saturating write-back. When kmer_len is zero or
// above MAX_K, or alphabet_size is above 32, the index loop is skipped.
// A finished result waits in the output register while the next beat is
// accepted; the write-back stalls only if that register is still full.
module kmer_profile_counter #(
    parameter int TABLE_DEPTH = 4096,
    parameter int NUM_SEQS    = 16,
    parameter int MAX_K       = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [kpc_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [kpc_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [kpc_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [kpc_pkg::FUNC_W-1:0]          s_func,
    input  logic [kpc_pkg::SEQ_ID_W-1:0]        s_seq_id,
    input  logic                                s_start_req,
    input  logic signed [kpc_pkg::SYMBOL_W-1:0] s_symbol,
    input  logic [kpc_pkg::READ_IDX_W-1:0]      s_read_index,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [kpc_pkg::KMER_IDX_W-1:0]      m_kmer_index,
    output logic                                m_index_valid,
    output logic [kpc_pkg::COUNT_W-1:0]         m_count,
    output logic [kpc_pkg::COUNT_W-1:0]         m_seq_length,
    output logic                                m_range_error
);
    import kpc_pkg::*;

    localparam int IDX_W     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int SEQ_W     = (NUM_SEQS > 1) ? $clog2(NUM_SEQS) : 1;
    localparam int ADDR_W    = SEQ_W + IDX_W;
    localparam int MEM_DEPTH = NUM_SEQS * (1 << IDX_W);
    localparam int KW        = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int RW        = $clog2(MAX_K + 1);
    localparam int P_W       = $clog2(TABLE_DEPTH + 2);
    localparam int PPROD_W   = P_W + ALPHA_W;
    localparam int HPROD_W   = IDX_W + ALPHA_W + 1;
    localparam logic [P_W-1:0] P_CAP = P_W'(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_FETCH,
        ST_UPDATE
    } state_t;

    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    logic [ALPHA_W-1:0]   alpha_reg, alpha_next;
    logic [KLEN_W-1:0]    klen_reg, klen_next;
    logic [SYM_W-1:0]     wnd_reg [MAX_K];
    logic [SYM_W-1:0]     wnd_next [MAX_K];
    logic [RW-1:0]        run_reg, run_next;
    logic                 func_reg, func_next;
    logic [SEQ_W-1:0]     seq_reg, seq_next;
    logic                 seq_ok_reg, seq_ok_next;
    logic [IDX_W-1:0]     ridx_reg, ridx_next;
    logic                 ridx_ok_reg, ridx_ok_next;
    logic                 hit_reg, hit_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [P_W-1:0]       pow_reg, pow_next;
    logic                 over_reg, over_next;
    logic [KW-1:0]        step_reg, step_next;
    logic                 m_valid_reg, m_valid_next;
    logic [KMER_IDX_W-1:0] m_kidx_reg, m_kidx_next;
    logic                 m_ivalid_reg, m_ivalid_next;
    logic [COUNT_W-1:0]   m_count_reg, m_count_next;
    logic [COUNT_W-1:0]   m_len_reg, m_len_next;
    logic                 m_err_reg, m_err_next;

    // Count and length stores, both with registered read data.
    logic [COUNT_W-1:0]   cnt_mem [MEM_DEPTH];
    logic [COUNT_W-1:0]   len_mem [NUM_SEQS];
    logic [COUNT_W-1:0]   cnt_rd_reg;
    logic [COUNT_W-1:0]   len_rd_reg;
    logic [ADDR_W-1:0]    cnt_addr;
    logic [SEQ_W-1:0]     len_addr;
    logic                 cnt_we, len_we;
    logic [COUNT_W-1:0]   cnt_wdata, len_wdata;

    logic                 accept, cfg_write, out_free, clearing;
    logic [7:0]           sym_raw;
    logic                 sym_ok, err_base, counted;
    logic [RW-1:0]        run_base;
    logic [31:0]          seq_ext, ridx_ext, idx_ext;
    logic [HPROD_W-1:0]   hprod;
    logic [PPROD_W-1:0]   pprod;
    logic [COUNT_W-1:0]   cnt_inc, len_inc;

    assign pready    = 1'b1;
    assign accept    = s_valid && s_ready;
    assign cfg_write = psel && penable && pwrite;
    assign out_free  = !m_valid_reg || m_ready;
    assign clearing  = (state_reg == ST_CLEAR);
    assign s_ready   = (state_reg == ST_IDLE);

    assign sym_raw  = s_symbol;
    assign sym_ok   = (sym_raw[7:SYM_W] == '0) && ({2'b00, alpha_reg} > sym_raw);
    assign err_base = (klen_reg == '0) || (32'(klen_reg) > MAX_K)
                      || (32'(alpha_reg) > MAX_ALPHA);
    assign seq_ext  = 32'(s_seq_id);
    assign ridx_ext = 32'(s_read_index);
    assign idx_ext  = 32'(idx_reg);
    assign run_base = s_start_req ? '0 : run_reg;

    assign hprod   = HPROD_W'(idx_reg) * HPROD_W'(alpha_reg) + HPROD_W'(wnd_reg[step_reg]);
    assign pprod   = PPROD_W'(pow_reg) * PPROD_W'(alpha_reg);
    assign cnt_inc = sat_inc(cnt_rd_reg);
    assign len_inc = sat_inc(len_rd_reg);
    // A k-mer is only counted with a usable table.
    assign counted = hit_reg && !over_reg;

    // Memory port control.
    always_comb begin
        cnt_addr  = clearing ? clr_reg
                             : {seq_reg, (func_reg == FUNC_READ) ? ridx_reg : idx_reg};
        len_addr  = clearing ? clr_reg[SEQ_W-1:0] : seq_reg;
        cnt_wdata = clearing ? '0 : cnt_inc;
        len_wdata = clearing ? '0 : len_inc;
        cnt_we    = 1'b0;
        len_we    = 1'b0;
        if (clearing) begin
            cnt_we = 1'b1;
            len_we = (32'(clr_reg) < NUM_SEQS);
        end else if (state_reg == ST_UPDATE && out_free && func_reg == FUNC_PUSH
                     && seq_ok_reg) begin
            len_we = 1'b1;
            cnt_we = counted;
        end
    end

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_addr] <= cnt_wdata;
        end
        cnt_rd_reg <= cnt_mem[cnt_addr];
    end

    always_ff @(posedge aclk) begin
        if (len_we) begin
            len_mem[len_addr] <= len_wdata;
        end
        len_rd_reg <= len_mem[len_addr];
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[2]))
            REG_ALPHABET_SIZE: prdata = APB_DATA_W'(alpha_reg);
            REG_KMER_LEN:      prdata = APB_DATA_W'(klen_reg);
            default:           prdata = '0;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        alpha_next    = alpha_reg;
        klen_next     = klen_reg;
        wnd_next      = wnd_reg;
        run_next      = run_reg;
        func_next     = func_reg;
        seq_next      = seq_reg;
        seq_ok_next   = seq_ok_reg;
        ridx_next     = ridx_reg;
        ridx_ok_next  = ridx_ok_reg;
        hit_next      = hit_reg;
        idx_next      = idx_reg;
        pow_next      = pow_reg;
        over_next     = over_reg;
        step_next     = step_reg;
        m_valid_next  = m_valid_reg;
        m_kidx_next   = m_kidx_reg;
        m_ivalid_next = m_ivalid_reg;
        m_count_next  = m_count_reg;
        m_len_next    = m_len_reg;
        m_err_next    = m_err_reg;

        if (cfg_write) begin
            unique case (reg_idx_t'(paddr[2]))
                REG_ALPHABET_SIZE: alpha_next = pwdata[ALPHA_W-1:0];
                REG_KMER_LEN:      klen_next  = pwdata[KLEN_W-1:0];
                default:           ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == ADDR_W'(MEM_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    func_next    = s_func;
                    seq_next     = seq_ext[SEQ_W-1:0];
                    seq_ok_next  = (seq_ext < NUM_SEQS);
                    ridx_next    = ridx_ext[IDX_W-1:0];
                    ridx_ok_next = (ridx_ext < TABLE_DEPTH);
                    hit_next     = 1'b0;
                    idx_next     = '0;
                    pow_next     = P_W'(1);
                    over_next    = err_base;
                    step_next    = KW'(32'(klen_reg) - 1);
                    if (s_func == FUNC_PUSH) begin
                        // Newest symbol enters at the head of the window.
                        for (int i = MAX_K - 1; i > 0; i--) begin
                            wnd_next[i] = wnd_reg[i-1];
                        end
                        wnd_next[0] = sym_ok ? sym_raw[SYM_W-1:0] : '0;
                        if (!sym_ok) begin
                            run_next = '0;
                        end else if (32'(run_base) < MAX_K) begin
                            run_next = run_base + 1'b1;
                        end else begin
                            run_next = run_base;
                        end
                        hit_next = sym_ok && (32'(run_next) >= 32'(klen_reg));
                    end
                    state_next = err_base ? ST_FETCH : ST_CALC;
                end
            end
            ST_CALC: begin
                // Horner step from the oldest symbol down; the power tracks
                // alphabet_size**kmer_len, clamped once past the table depth.
                idx_next = IDX_W'(hprod);
                if (32'(pprod) > TABLE_DEPTH) begin
                    over_next = 1'b1;
                    pow_next  = P_CAP;
                end else begin
                    pow_next = P_W'(pprod);
                end
                if (step_reg == '0) begin
                    state_next = ST_FETCH;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            ST_FETCH: begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_err_next   = over_reg;
                    if (func_reg == FUNC_PUSH) begin
                        m_ivalid_next = counted;
                        m_kidx_next   = counted ? idx_ext[KMER_IDX_W-1:0] : '0;
                        m_count_next  = (counted && seq_ok_reg) ? cnt_inc : '0;
                        m_len_next    = seq_ok_reg ? len_inc : '0;
                    end else begin
                        m_ivalid_next = 1'b0;
                        m_kidx_next   = '0;
                        m_count_next  = (seq_ok_reg && ridx_ok_reg) ? cnt_rd_reg : '0;
                        m_len_next    = seq_ok_reg ? len_rd_reg : '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            alpha_reg   <= ALPHA_RESET;
            klen_reg    <= KLEN_RESET;
            run_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_K; i++) begin
                wnd_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            alpha_reg   <= alpha_next;
            klen_reg    <= klen_next;
            run_reg     <= run_next;
            m_valid_reg <= m_valid_next;
            wnd_reg     <= wnd_next;
        end
        func_reg     <= func_next;
        seq_reg      <= seq_next;
        seq_ok_reg   <= seq_ok_next;
        ridx_reg     <= ridx_next;
        ridx_ok_reg  <= ridx_ok_next;
        hit_reg      <= hit_next;
        idx_reg      <= idx_next;
        pow_reg      <= pow_next;
        over_reg     <= over_next;
        step_reg     <= step_next;
        m_kidx_reg   <= m_kidx_next;
        m_ivalid_reg <= m_ivalid_next;
        m_count_reg  <= m_count_next;
        m_len_reg    <= m_len_next;
        m_err_reg    <= m_err_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_kmer_index  = m_kidx_reg;
    assign m_index_valid = m_ivalid_reg;
    assign m_count       = m_count_reg;
    assign m_seq_length  = m_len_reg;
    assign m_range_error = m_err_reg;

    // No beat may be taken while the count memory is being cleared.
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clearing |-> !s_ready)
        else $error("beat accepted during clearing pass");

    // A counted k-mer never comes with a range error.
    a_count_no_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_index_valid && m_range_error))
        else $error("k-mer counted despite range error");

    // One beat at a time: the input closes straight after an accept.
    a_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("second beat accepted while one is in progress");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the k-mer profile counter. A behavioural profile
// model predicts every result beat from the accepted input beats and the
// register settings, and checks each result field by field. The stimulus
// covers directed corner cases, then random symbol runs over a range of
// alphabet sizes and k-mer lengths, including settings with no usable table.
// ----------------------------------------------------------------------------
module tb;
    import kpc_pkg::*;

    localparam int TABLE_DEPTH   = 4096;
    localparam int NUM_SEQS      = 16;
    localparam int MAX_K         = 8;
    localparam int PHASES        = 15;
    localparam int PHASE_BEATS   = 100;
    localparam int STEADY_PHASE  = 13;
    localparam int SETTLE_CYCLES = 16;

    localparam int PHASE_ALPHA [PHASES] = '{1, 32, 32, 2, 4, 16, 8, 0, 33, 63, 5, 3, 32, 4, 7};
    localparam int PHASE_KLEN  [PHASES] = '{1, 1, 2, 8, 6, 3, 4, 3, 2, 15, 0, 9, 8, 3, 4};

    typedef struct packed {
        logic [KMER_IDX_W-1:0] kmer_index;
        logic                  index_valid;
        logic [COUNT_W-1:0]    count;
        logic [COUNT_W-1:0]    seq_length;
        logic                  range_error;
    } kmer_result_t;

    class kmer_profile_model;
        logic [ALPHA_W-1:0] alpha;
        logic [KLEN_W-1:0]  klen;
        logic [SYM_W-1:0]   window [MAX_K];
        int unsigned        run_len;
        logic [COUNT_W-1:0] counts [NUM_SEQS][TABLE_DEPTH];
        logic [COUNT_W-1:0] lengths [NUM_SEQS];
        kmer_result_t       pending_results [$];
        int unsigned        errors;

        function new();
            alpha   = ALPHA_RESET;
            klen    = KLEN_RESET;
            run_len = 0;
            errors  = 0;
            foreach (window[i]) window[i] = '0;
            foreach (lengths[s]) lengths[s] = '0;
            foreach (counts[s, i]) counts[s][i] = '0;
        endfunction

        function void set_reg(reg_idx_t r, logic [APB_DATA_W-1:0] value);
            if (r == REG_ALPHABET_SIZE) begin
                alpha = value[ALPHA_W-1:0];
            end else begin
                klen = value[KLEN_W-1:0];
            end
        endfunction

        // True when kmer_len or alphabet_size is out of range, or alphabet_size**kmer_len exceeds the table depth.
        function bit table_unusable();
            longint span;
            span = 1;
            if (klen == 0 || klen > MAX_K || alpha > MAX_ALPHA) return 1'b1;
            for (int i = 0; i < klen; i++) begin
                span = span * alpha;
                if (span > TABLE_DEPTH) return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_input(func_t f, logic [SEQ_ID_W-1:0] seq, logic st,
                                 logic [SYMBOL_W-1:0] sym, logic [READ_IDX_W-1:0] ridx);
            kmer_result_t r;
            bit           sym_ok;
            int unsigned  idx;
            r = '0;
            r.range_error = table_unusable();
            if (f == FUNC_READ) begin
                r.seq_length = lengths[seq];
                r.count      = counts[seq][ridx];
            end else begin
                sym_ok = !sym[SYMBOL_W-1] && sym < alpha && sym < MAX_ALPHA;
                if (st) run_len = 0;
                for (int i = MAX_K - 1; i > 0; i--) window[i] = window[i-1];
                window[0] = sym_ok ? sym[SYM_W-1:0] : '0;
                if (!sym_ok) begin
                    run_len = 0;
                end else if (run_len < MAX_K) begin
                    run_len++;
                end
                if (lengths[seq] != '1) lengths[seq]++;
                r.seq_length = lengths[seq];
                if (!r.range_error && sym_ok && run_len >= klen) begin
                    // The oldest symbol of the k-mer is the most significant digit.
                    idx = 0;
                    for (int k = klen - 1; k >= 0; k--) idx = idx * alpha + window[k];
                    if (idx < TABLE_DEPTH) begin
                        r.kmer_index  = idx[KMER_IDX_W-1:0];
                        r.index_valid = 1'b1;
                        if (counts[seq][idx] != '1) counts[seq][idx]++;
                        r.count = counts[seq][idx];
                    end
                end
            end
            pending_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, seen);
                errors++;
            end
        endfunction

        function void check_result(kmer_result_t seen);
            kmer_result_t want;
            if (pending_results.size() == 0) begin
                $error("result beat arrived with no expectation waiting");
                errors++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("kmer_index", 32'(want.kmer_index), 32'(seen.kmer_index));
            compare_field("index_valid", 32'(want.index_valid), 32'(seen.index_valid));
            compare_field("count", 32'(want.count), 32'(seen.count));
            compare_field("seq_length", 32'(want.seq_length), 32'(seen.seq_length));
            compare_field("range_error", 32'(want.range_error), 32'(seen.range_error));
        endfunction
    endclass

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          psel = 1'b0;
    logic                          penable = 1'b0;
    logic                          pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]         paddr = '0;
    logic [APB_DATA_W-1:0]         pwdata = '0;
    logic [APB_DATA_W-1:0]         prdata;
    logic                          pready;
    logic                          s_valid = 1'b0;
    logic                          s_ready;
    logic [FUNC_W-1:0]             s_func = '0;
    logic [SEQ_ID_W-1:0]           s_seq_id = '0;
    logic                          s_start_req = 1'b0;
    logic signed [SYMBOL_W-1:0]    s_symbol = '0;
    logic [READ_IDX_W-1:0]         s_read_index = '0;
    logic                          m_valid;
    logic                          m_ready = 1'b0;
    logic [KMER_IDX_W-1:0]         m_kmer_index;
    logic                          m_index_valid;
    logic [COUNT_W-1:0]            m_count;
    logic [COUNT_W-1:0]            m_seq_length;
    logic                          m_range_error;

    bit                            no_idle = 1'b0;
    kmer_profile_model             profile_model = new();

    kmer_profile_counter #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .NUM_SEQS    (NUM_SEQS),
        .MAX_K       (MAX_K)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_seq_id      (s_seq_id),
        .s_start_req   (s_start_req),
        .s_symbol      (s_symbol),
        .s_read_index  (s_read_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kmer_index  (m_kmer_index),
        .m_index_valid (m_index_valid),
        .m_count       (m_count),
        .m_seq_length  (m_seq_length),
        .m_range_error (m_range_error)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready = no_idle || ($urandom_range(0, 99) >= 16);
    end

    always @(posedge aclk) begin : monitor
        kmer_result_t seen;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen = '{m_kmer_index, m_index_valid, m_count, m_seq_length, m_range_error};
                profile_model.check_result(seen);
            end
            if (s_valid && s_ready) begin
                profile_model.note_input(func_t'(s_func), s_seq_id, s_start_req,
                                         s_symbol, s_read_index);
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken,
    // with valid still high so that the next beat can follow back to back.
    task automatic send_beat(func_t f, logic [SEQ_ID_W-1:0] seq, logic st,
                             logic [SYMBOL_W-1:0] sym, logic [READ_IDX_W-1:0] ridx);
        while (!no_idle && $urandom_range(0, 99) < 16) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_func       = f;
        s_seq_id     = seq;
        s_start_req  = st;
        s_symbol     = sym;
        s_read_index = ridx;
        s_valid      = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic push_symbol(logic [SEQ_ID_W-1:0] seq, logic st, logic [SYMBOL_W-1:0] sym);
        send_beat(FUNC_PUSH, seq, st, sym, READ_IDX_W'($urandom));
    endtask

    task automatic read_entry(logic [SEQ_ID_W-1:0] seq, logic [READ_IDX_W-1:0] ridx);
        send_beat(FUNC_READ, seq, 1'($urandom), SYMBOL_W'($urandom), ridx);
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (profile_model.pending_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(reg_idx_t r, logic [APB_DATA_W-1:0] value);
        paddr   = APB_ADDR_W'({r, 2'b00});
        pwdata  = value;
        pwrite  = 1'b1;
        psel    = 1'b1;
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        profile_model.set_reg(r, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    initial begin : stimulus
        logic [APB_DATA_W-1:0] cfg_word;
        longint                span;
        int unsigned           sym_top;
        int unsigned           beats;
        int unsigned           run_left;
        int unsigned           pick;
        logic [SEQ_ID_W-1:0]   cur_seq;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Default settings: alphabet of four, k-mers of three.
        push_symbol(0, 1'b1, 8'd0);
        push_symbol(0, 1'b0, 8'd1);
        push_symbol(0, 1'b0, 8'd2);
        push_symbol(0, 1'b0, 8'd3);
        push_symbol(0, 1'b0, 8'h80);
        push_symbol(0, 1'b0, 8'h7F);
        push_symbol(0, 1'b0, 8'd4);
        push_symbol(0, 1'b0, 8'hFF);
        push_symbol(0, 1'b0, 8'd1);
        push_symbol(0, 1'b0, 8'd2);
        // A start in the middle of a run must restart the run, so no k-mer spans it.
        push_symbol(0, 1'b1, 8'd3);
        push_symbol(0, 1'b0, 8'd0);
        push_symbol(0, 1'b0, 8'd3);
        push_symbol(15, 1'b1, 8'd3);
        push_symbol(15, 1'b0, 8'd3);
        push_symbol(15, 1'b0, 8'd3);
        push_symbol(15, 1'b0, 8'd3);
        read_entry(15, 12'd63);
        read_entry(0, 12'd6);
        read_entry(15, 12'hFFF);
        read_entry(0, 12'd0);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            cfg_word = $urandom;
            cfg_word[ALPHA_W-1:0] = ALPHA_W'(PHASE_ALPHA[p]);
            write_reg(REG_ALPHABET_SIZE, cfg_word);
            cfg_word = $urandom;
            cfg_word[KLEN_W-1:0] = KLEN_W'(PHASE_KLEN[p]);
            write_reg(REG_KMER_LEN, cfg_word);
            no_idle = (p == STEADY_PHASE);

            // Reads mostly aim inside the reachable part of the table to hit live counters.
            span = 1;
            for (int i = 0; i < PHASE_KLEN[p] && span <= TABLE_DEPTH; i++) begin
                span = span * PHASE_ALPHA[p];
            end
            if (span > TABLE_DEPTH) span = TABLE_DEPTH;
            if (span < 1) span = 1;
            sym_top = (PHASE_ALPHA[p] == 0) ? 0 :
                      (PHASE_ALPHA[p] > MAX_ALPHA) ? MAX_ALPHA - 1 : PHASE_ALPHA[p] - 1;

            beats = 0;
            while (beats < PHASE_BEATS) begin
                cur_seq  = SEQ_ID_W'($urandom);
                run_left = $urandom_range(1, 24);
                push_symbol(cur_seq, 1'b1, SYMBOL_W'($urandom_range(0, sym_top)));
                beats++;
                while (run_left > 0 && beats < PHASE_BEATS) begin
                    pick = $urandom_range(0, 99);
                    if (pick < 18) begin
                        read_entry($urandom_range(0, 1) ? cur_seq : SEQ_ID_W'($urandom),
                                   ($urandom_range(0, 2) == 0) ? READ_IDX_W'($urandom) :
                                   READ_IDX_W'($urandom_range(0, 32'(span - 1))));
                    end else if (pick < 30) begin
                        push_symbol(cur_seq, ($urandom_range(0, 9) == 0), SYMBOL_W'($urandom));
                    end else begin
                        push_symbol(cur_seq, 1'b0, SYMBOL_W'($urandom_range(0, sym_top)));
                    end
                    run_left--;
                    beats++;
                end
            end
        end

        drain();
        if (profile_model.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
